>>> hdl/lcd_mode_timing_sequencer_assert.svh
// Assertion macros shared by the LCD mode timing checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH
`define LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LMTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LMTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lmts_pkg.sv
// Package for the LCD mode timing sequencer: mode codes, dot thresholds,
// line limits and config register indexes. No dependencies.
`default_nettype none

package lmts_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef enum logic [1:0] {
    REG_LCD_ON       = 2'd0,
    REG_STAT_IRQ_EN  = 2'd1,
    REG_LINE_COMPARE = 2'd2
  } cfg_reg_t;

  localparam int unsigned ACCUM_W = 10;

  localparam logic [ACCUM_W-1:0] DOTS_OAM    = 10'd80;
  localparam logic [ACCUM_W-1:0] DOTS_XFER   = 10'd172;
  localparam logic [ACCUM_W-1:0] DOTS_HBLANK = 10'd204;
  localparam logic [ACCUM_W-1:0] DOTS_LINE   = 10'd456;

  localparam logic [7:0] LAST_VISIBLE = 8'h8F;
  localparam logic [7:0] LAST_LINE    = 8'h8F + 8'd10;

  // stat_irq_enables bit positions
  localparam int unsigned EN_HBLANK  = 0;
  localparam int unsigned EN_VBLANK  = 1;
  localparam int unsigned EN_OAM     = 2;
  localparam int unsigned EN_COMPARE = 3;

endpackage

`default_nettype wire

>>> hdl/lcd_mode_timing_sequencer.sv
// LCD mode timing sequencer: line-clock accumulator, mode/line sequencing,
// coincidence flag and interrupt pulses. Depends on lmts_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | elapsed_cycles
//  out      | out_valid/ out_ready | mode, line, coincidence, vblank_irq,
//           |                      | stat_irq, render_line
//  cfg      | cfg_we               | cfg_addr, cfg_wdata
//
// One word per cycle while the consumer keeps up; the result is registered and appears in the
// cycle after its input is taken. The add/saturate/compare/subtract on the accumulator is
// the single stage. in_ready is high whenever the output register is empty or being drained,
// so a stalled consumer stalls input only while a result is held.
// Synchronous reset: mode = OAM scan, line 0, accumulator 0, lcd_on = 1.
`default_nettype none

module lcd_mode_timing_sequencer
  import lmts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] elapsed_cycles,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      mode,
  output logic [7:0]      line,
  output logic            coincidence,
  output logic            vblank_irq,
  output logic            stat_irq,
  output logic            render_line,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata
);

  logic         lcd_on;
  logic [3:0]   stat_irq_enables;
  logic [7:0]   line_compare;

  lcd_mode_t        mode_reg, mode_reg_next;
  logic [7:0]       line_count, line_count_next;
  logic [ACCUM_W-1:0] dot_accum, dot_accum_next;
  logic             match_flag, match_flag_next;
  logic             vblank_next, stat_next, render_next;

  logic [ACCUM_W:0]   sum;
  logic [ACCUM_W-1:0] sat;
  logic [ACCUM_W-1:0] thresh;
  logic [ACCUM_W-1:0] remain;
  logic               reached;
  logic [7:0]         line_inc;
  logic               accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_on           <= 1'b1;
      stat_irq_enables <= '0;
      line_compare     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LCD_ON:       lcd_on           <= cfg_wdata[0];
        REG_STAT_IRQ_EN:  stat_irq_enables <= cfg_wdata[3:0];
        REG_LINE_COMPARE: line_compare     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum      = {1'b0, dot_accum} + {{(ACCUM_W-7){1'b0}}, elapsed_cycles};
    sat      = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
    unique case (mode_reg)
      MODE_OAM:    thresh = DOTS_OAM;
      MODE_XFER:   thresh = DOTS_XFER;
      MODE_HBLANK: thresh = DOTS_HBLANK;
      default:     thresh = DOTS_LINE;
    endcase
    reached  = (sat >= thresh);
    remain   = sat - thresh;
    line_inc = line_count + 8'd1;
  end

  // one transition at most per word
  always_comb begin
    mode_reg_next   = mode_reg;
    line_count_next = line_count;
    dot_accum_next  = dot_accum;
    match_flag_next = match_flag;
    vblank_next     = 1'b0;
    stat_next       = 1'b0;
    render_next     = 1'b0;
    if (lcd_on) begin
      dot_accum_next = reached ? remain : sat;
      if (reached) begin
        unique case (mode_reg)
          MODE_OAM: begin
            mode_reg_next = MODE_XFER;
          end
          MODE_XFER: begin
            mode_reg_next = MODE_HBLANK;
            render_next   = 1'b1;
            stat_next     = stat_irq_enables[EN_HBLANK];
          end
          MODE_HBLANK: begin
            line_count_next = line_inc;
            match_flag_next = (line_inc == line_compare);
            if (line_count == LAST_VISIBLE) begin
              mode_reg_next = MODE_VBLANK;
              vblank_next   = 1'b1;
              stat_next     = stat_irq_enables[EN_VBLANK];
            end else begin
              mode_reg_next = MODE_OAM;
              stat_next     = stat_irq_enables[EN_OAM];
            end
            if ((line_inc == line_compare) && stat_irq_enables[EN_COMPARE]) begin
              stat_next = 1'b1;
            end
          end
          default: begin
            if (line_count == LAST_LINE) begin
              line_count_next = '0;
              mode_reg_next   = MODE_OAM;
              stat_next       = stat_irq_enables[EN_OAM];
            end else begin
              line_count_next = line_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= MODE_OAM;
      line_count <= '0;
      dot_accum  <= '0;
      match_flag <= 1'b0;
    end else if (accept) begin
      mode_reg   <= mode_reg_next;
      line_count <= line_count_next;
      dot_accum  <= dot_accum_next;
      match_flag <= match_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      mode        <= mode_reg_next;
      line        <= line_count_next;
      coincidence <= match_flag_next;
      vblank_irq  <= vblank_next;
      stat_irq    <= stat_next;
      render_line <= render_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lmts_checker.sv
// Port-level checker for the LCD mode timing sequencer, bound to the top.
// Depends on lmts_pkg and lcd_mode_timing_sequencer_assert.svh.
`default_nettype none

`include "lcd_mode_timing_sequencer_assert.svh"

module lmts_checker
  import lmts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] mode,
  input wire logic [7:0] line,
  input wire logic       vblank_irq,
  input wire logic       render_line
);

  // a rendered line always leaves the sequencer in hblank
  `LMTS_ASSERT_IMPL(a_render_hblank, clk, rst, out_valid && render_line, mode == 2'(MODE_HBLANK), "render_line without hblank")

  // vblank starts exactly on the first line past the visible area
  `LMTS_ASSERT_IMPL(a_vblank_entry, clk, rst, out_valid && vblank_irq, (mode == 2'(MODE_VBLANK)) && (line == LAST_VISIBLE + 8'd1), "vblank_irq off frame end")

  // line counter stays in its range
  `LMTS_ASSERT_IMPL(a_line_range, clk, rst, out_valid, line <= LAST_LINE, "line out of range")

  // held word keeps its payload
  `LMTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mode) && $stable(line), "stalled word changed")

endmodule

bind lcd_mode_timing_sequencer lmts_checker u_lmts_checker (.*);

`default_nettype wire

>>> tb/sv/tb_lcd_mode_timing_sequencer.sv
// Testbench for lcd_mode_timing_sequencer: drives cycle-count words, predicts each status
// word with an in-bench timing model, and checks every field. Depends on lmts_pkg and
// the RTL.
module tb_lcd_mode_timing_sequencer;
  import lmts_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;

  typedef struct packed {
    lcd_mode_t  mode;
    logic [7:0] line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       render_line;
  } lcd_status_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] elapsed_cycles;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic       coincidence;
  logic       vblank_irq;
  logic       stat_irq;
  logic       render_line;
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_wdata;

  lcd_mode_timing_sequencer DUT (.*);

  // timing model state and its copy of the registers
  lcd_mode_t   seq_mode;
  logic [7:0]  seq_line;
  logic [9:0]  seq_dots;
  logic        seq_match;
  logic        lcd_enable;
  logic [3:0]  irq_enables;
  logic [7:0]  compare_line;
  int          frames_seen;

  lcd_status_t pending_status[$];
  int          err_count;
  int          cycle_count;
  bit          valid_q;
  bit          idle_on;
  bit          stall_on;
  int          stall_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (rst || !stall_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic lcd_status_t advance_timing(input logic [7:0] cyc);
    lcd_status_t r;
    logic [10:0] sum;
    logic [7:0]  ended;
    r = '0;
    if (lcd_enable) begin
      sum = {1'b0, seq_dots} + {3'b0, cyc};
      seq_dots = (sum > 11'd1023) ? 10'd1023 : sum[9:0];
      case (seq_mode)
        MODE_OAM: begin
          if (seq_dots >= DOTS_OAM) begin
            seq_dots -= DOTS_OAM;
            seq_mode = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (seq_dots >= DOTS_XFER) begin
            seq_dots -= DOTS_XFER;
            seq_mode = MODE_HBLANK;
            r.stat_irq = irq_enables[EN_HBLANK];
            r.render_line = 1'b1;
          end
        end
        MODE_HBLANK: begin
          if (seq_dots >= DOTS_HBLANK) begin
            ended = seq_line;
            seq_dots -= DOTS_HBLANK;
            seq_line = seq_line + 8'd1;
            if (ended == LAST_VISIBLE) begin
              seq_mode = MODE_VBLANK;
              r.stat_irq = irq_enables[EN_VBLANK];
              r.vblank_irq = 1'b1;
            end else begin
              seq_mode = MODE_OAM;
              r.stat_irq = irq_enables[EN_OAM];
            end
            // coincidence only refreshes at the end of hblank
            seq_match = (seq_line == compare_line);
            if (seq_match && irq_enables[EN_COMPARE]) r.stat_irq = 1'b1;
          end
        end
        MODE_VBLANK: begin
          if (seq_dots >= DOTS_LINE) begin
            ended = seq_line;
            seq_dots -= DOTS_LINE;
            seq_line = seq_line + 8'd1;
            if (ended == LAST_LINE) begin
              seq_line = 8'd0;
              seq_mode = MODE_OAM;
              r.stat_irq = irq_enables[EN_OAM];
              frames_seen++;
            end
          end
        end
      endcase
    end
    r.mode = seq_mode;
    r.line = seq_line;
    r.coincidence = seq_match;
    return r;
  endfunction

  function automatic logic [7:0] pick_cycles();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'($urandom_range(0, 7));
    if (sel == 1) return 8'd255;
    if (sel <= 4) return 8'($urandom_range(200, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lcd_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        err_count++;
        $display("%0t: status word with none expected: mode %0d line %0d",
                 $time, mode, line);
      end else begin
        want = pending_status.pop_front();
        check_field("mode", want.mode, mode);
        check_field("line", want.line, line);
        check_field("coincidence", want.coincidence, coincidence);
        check_field("vblank_irq", want.vblank_irq, vblank_irq);
        check_field("stat_irq", want.stat_irq, stat_irq);
        check_field("render_line", want.render_line, render_line);
      end
    end
  end

  // keeps at most one update of in_valid per time step
  task automatic set_valid(input bit v);
    if (valid_q != v) begin
      in_valid <= v;
      valid_q = v;
    end
  endtask

  // enter and leave at a falling edge; valid stays up for a back-to-back word
  task automatic send_word(input logic [7:0] cyc);
    int gap;
    gap = (idle_on && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      set_valid(1'b0);
      repeat (gap) @(negedge clk);
    end
    elapsed_cycles <= cyc;
    set_valid(1'b1);
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(advance_timing(cyc));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    set_valid(1'b0);
    while (pending_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LCD_ON:       lcd_enable = val[0];
      REG_STAT_IRQ_EN:  irq_enables = val[3:0];
      REG_LINE_COMPARE: compare_line = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] seq [15];
    seq = '{8'd0, 8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd170, 8'd85, 8'd128,
            8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    write_cfg(REG_STAT_IRQ_EN, 8'hFF);
    write_cfg(REG_LINE_COMPARE, 8'd1);
    foreach (seq[i]) send_word(seq[i]);
    wait_drain();
    // display off: upper data bits are dropped, items leave state alone
    write_cfg(REG_LCD_ON, 8'hFE);
    send_word(8'd255);
    send_word(8'd37);
    wait_drain();
    write_cfg(REG_LCD_ON, 8'h01);
  endtask

  // run fast words until the frame wraps back to line 0
  task automatic test_frame_wrap();
    int start;
    write_cfg(REG_STAT_IRQ_EN, 8'(1 << EN_VBLANK));
    write_cfg(REG_LINE_COMPARE, 8'h90);
    start = frames_seen;
    while (frames_seen == start) send_word(8'($urandom_range(180, 255)));
    wait_drain();
  endtask

  task automatic test_random_sweep();
    logic [7:0] en_set [6];
    logic [7:0] cmp_set [6];
    en_set = '{8'h00, 8'h0F, 8'h01, 8'h02, 8'h0C, 8'h00};
    cmp_set = '{8'd0, 8'd255, 8'd10, 8'd144, 8'd153, 8'd0};
    en_set[5] = 8'($urandom_range(0, 15));
    cmp_set[5] = 8'($urandom_range(0, 153));
    for (int p = 0; p < 6; p++) begin
      write_cfg(REG_STAT_IRQ_EN, en_set[p]);
      write_cfg(REG_LINE_COMPARE, cmp_set[p]);
      idle_on = (p != 2);
      stall_on = (p != 3);
      repeat (200) send_word(pick_cycles());
      wait_drain();
    end
  endtask

  task automatic test_display_off();
    write_cfg(REG_LCD_ON, 8'h00);
    repeat (40) send_word(pick_cycles());
    wait_drain();
    write_cfg(REG_LCD_ON, 8'h01);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    stall_on = 1'b0;
    write_cfg(REG_STAT_IRQ_EN, 8'h0F);
    write_cfg(REG_LINE_COMPARE, 8'($urandom_range(0, 153)));
    repeat (300) send_word(pick_cycles());
    wait_drain();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    elapsed_cycles = 8'd0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_LCD_ON;
    cfg_wdata = 8'd0;
    valid_q = 1'b0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    stall_left = 0;
    err_count = 0;
    cycle_count = 0;
    frames_seen = 0;
    seq_mode = MODE_OAM;
    seq_line = 8'd0;
    seq_dots = 10'd0;
    seq_match = 1'b0;
    lcd_enable = 1'b1;
    irq_enables = 4'd0;
    compare_line = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_frame_wrap();
    test_random_sweep();
    test_display_off();
    test_steady_stream();

    repeat (4) @(negedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
